// File: rtl/core/phpc_pkg.sv
`default_nettype none

package phpc_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] CSR_SETPOINT  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PROP_GAIN = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PERIOD    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_INT_TIME  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DER_TIME  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_PWM_CYCLE = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_OUT   = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_KI,
      ST_DIV_KD,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_P,
      MUL_I,
      MUL_D
   } mul_op_type;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_ADD_CLAMP,
      ACC_ADD
   } acc_op_type;

   typedef enum logic {
      DIV_KI,
      DIV_KD
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        err_update;
      logic        div_start;
      div_sel_type div_sel;
      logic        save_ki;
      logic        save_kd;
      mul_op_type  mul_op;
      acc_op_type  acc_op;
      logic        commit;
   } cmd_type;

   typedef struct packed {
      logic pid_due;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/core/phpc_div.sv
`default_nettype none

module phpc_div import phpc_pkg::*; #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

`default_nettype wire

// File: rtl/core/phpc_ctrl.sv
`default_nettype none

module phpc_ctrl import phpc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '{load: 1'b0, err_update: 1'b0, div_start: 1'b0, div_sel: DIV_KI,
                     save_ki: 1'b0, save_kd: 1'b0, mul_op: MUL_P, acc_op: ACC_NONE,
                     commit: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.pid_due) begin
               cmd.err_update = 1'b1;
               cmd.div_start  = 1'b1;
               cmd.div_sel    = DIV_KI;
               state_in       = ST_DIV_KI;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV_KI: begin
            if (status.div_done) begin
               cmd.save_ki   = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_KD;
               state_in      = ST_DIV_KD;
            end
         end
         ST_DIV_KD: begin
            if (status.div_done) begin
               cmd.save_kd = 1'b1;
               state_in    = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            cmd.mul_op = MUL_P;
            state_in   = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.mul_op = MUL_I;
            cmd.acc_op = ACC_LOAD;
            state_in   = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_op = MUL_D;
            cmd.acc_op = ACC_ADD_CLAMP;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_op = ACC_ADD;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/phpc_dpath.sv
`default_nettype none

module phpc_dpath import phpc_pkg::*; #(
   parameter int SAMPLE_BITS = 12,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [15:0]           req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [31:0]                rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire cmd_type               cmd,
   output status_type                 status
);

   localparam int ERR_W  = SAMPLE_BITS + 1;
   localparam int NUM_W  = 32 + FRAC_BITS;
   localparam int OP_W   = 33;
   localparam int ACC_W  = 2 * OP_W;
   localparam logic signed [ACC_W-1:0] ITERM_LIM = ACC_W'(64'sd1 <<< 62);

   logic [11:0] sp_ff;
   logic [15:0] kp_ff, period_cfg_ff, td_ff, pwm_cycle_ff, min_out_ff;
   logic [23:0] ti_ff;

   logic [11:0]             meas_ff, meas_in;
   logic signed [31:0]      esum_ff, esum_in;
   logic signed [ERR_W-1:0] last_err_ff, last_err_in;
   logic [15:0]             period_ff, period_in;
   logic [15:0]             pwm_ff, pwm_in;
   logic [15:0]             duty_ff, duty_in;
   logic                    due_ff, due_in;
   logic [31:0]             ki_ff, kd_ff;
   logic signed [ACC_W-1:0] prod_ff, acc_ff, acc_in;
   logic                    valid_ff, valid_in;
   logic [31:0]             data_ff, data_in;

   logic [15:0]             t_eff, sp16, meas16, period_inc;
   logic [23:0]             ti_eff;
   logic signed [ERR_W-1:0] err;
   logic signed [ERR_W:0]   derr;
   logic signed [32:0]      esum_wide;
   logic [31:0]             kprod;
   logic [NUM_W-1:0]        div_num, div_quot;
   logic [23:0]             div_den;
   logic                    div_done;
   logic [31:0]             gain_sat;
   logic signed [OP_W-1:0]  mul_a, mul_b;
   logic signed [ACC_W-1:0] iterm, top;
   logic [15:0]             duty_calc, pwm_inc;
   logic signed [ERR_W-1:0] err_out;

   assign t_eff  = (period_cfg_ff == 16'd0) ? 16'd1 : period_cfg_ff;
   assign ti_eff = (ti_ff == 24'd0) ? 24'd1 : ti_ff;
   assign sp16   = 16'(sp_ff);
   assign meas16 = 16'(meas_ff);
   assign err    = $signed({1'b0, sp16[SAMPLE_BITS-1:0]})
                   - $signed({1'b0, meas16[SAMPLE_BITS-1:0]});
   assign derr   = (ERR_W+1)'(err) - (ERR_W+1)'(last_err_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff         <= 12'd120;
         kp_ff         <= 16'd30;
         period_cfg_ff <= 16'd500;
         ti_ff         <= 24'd5000000;
         td_ff         <= 16'd1000;
         pwm_cycle_ff  <= 16'd200;
         min_out_ff    <= 16'd1;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SETPOINT:  sp_ff         <= csr_wdata[11:0];
            CSR_PROP_GAIN: kp_ff         <= csr_wdata[15:0];
            CSR_PERIOD:    period_cfg_ff <= csr_wdata[15:0];
            CSR_INT_TIME:  ti_ff         <= csr_wdata;
            CSR_DER_TIME:  td_ff         <= csr_wdata[15:0];
            CSR_PWM_CYCLE: pwm_cycle_ff  <= csr_wdata[15:0];
            CSR_MIN_OUT:   min_out_ff    <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign kprod   = (cmd.div_sel == DIV_KI) ? kp_ff * t_eff : kp_ff * td_ff;
   assign div_num = {kprod, FRAC_BITS'(0)};
   assign div_den = (cmd.div_sel == DIV_KI) ? ti_eff : 24'(t_eff);

   phpc_div #(
      .NUM_W (NUM_W),
      .DEN_W (24)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign gain_sat = (|div_quot[NUM_W-1:32]) ? 32'hFFFFFFFF : div_quot[31:0];

   always_comb begin
      case (cmd.mul_op)
         MUL_P: begin
            mul_a = $signed({17'd0, kp_ff});
            mul_b = OP_W'(err);
         end
         MUL_I: begin
            mul_a = $signed({1'b0, ki_ff});
            mul_b = OP_W'(esum_ff);
         end
         MUL_D: begin
            mul_a = $signed({1'b0, kd_ff});
            mul_b = OP_W'(derr);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      if (prod_ff > ITERM_LIM) begin
         iterm = ITERM_LIM;
      end else if (prod_ff < -ITERM_LIM) begin
         iterm = -ITERM_LIM;
      end else begin
         iterm = prod_ff;
      end
      case (cmd.acc_op)
         ACC_LOAD:      acc_in = prod_ff <<< FRAC_BITS;
         ACC_ADD_CLAMP: acc_in = acc_ff + iterm;
         ACC_ADD:       acc_in = acc_ff + prod_ff;
         default:       acc_in = acc_ff;
      endcase
   end

   assign top = $signed({(ACC_W-16)'(0), pwm_cycle_ff}) <<< FRAC_BITS;

   always_comb begin
      if (acc_ff > top) begin
         duty_calc = pwm_cycle_ff;
      end else if (acc_ff < 0) begin
         duty_calc = min_out_ff;
      end else begin
         duty_calc = acc_ff[FRAC_BITS +: 16];
      end
   end

   assign period_inc = (period_ff == 16'hFFFF) ? period_ff : period_ff + 16'd1;
   assign esum_wide  = 33'(esum_ff) + 33'(err);
   assign pwm_inc    = pwm_ff + 16'd1;

   always_comb begin
      meas_in     = meas_ff;
      period_in   = period_ff;
      due_in      = due_ff;
      esum_in     = esum_ff;
      last_err_in = last_err_ff;
      duty_in     = duty_ff;
      pwm_in      = pwm_ff;
      valid_in    = valid_ff && !rsp_tready;
      data_in     = data_ff;
      err_out     = last_err_ff;
      if (cmd.load) begin
         meas_in   = req_tdata[11:0];
         period_in = period_inc;
         due_in    = (period_inc >= t_eff);
      end
      if (cmd.err_update) begin
         if (esum_wide[32] != esum_wide[31]) begin
            esum_in = esum_wide[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
         end else begin
            esum_in = esum_wide[31:0];
         end
      end
      if (cmd.commit) begin
         if (due_ff) begin
            duty_in     = duty_calc;
            last_err_in = err;
            period_in   = 16'd0;
            err_out     = err;
         end
         pwm_in   = (pwm_inc >= pwm_cycle_ff) ? 16'd0 : pwm_inc;
         valid_in = 1'b1;
         data_in  = {1'b0, 13'(err_out), due_ff, duty_in, (pwm_in < duty_in)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= '0;
         due_ff      <= 1'b0;
         esum_ff     <= '0;
         last_err_ff <= '0;
         duty_ff     <= '0;
         pwm_ff      <= '0;
         valid_ff    <= 1'b0;
      end else begin
         period_ff   <= period_in;
         due_ff      <= due_in;
         esum_ff     <= esum_in;
         last_err_ff <= last_err_in;
         duty_ff     <= duty_in;
         pwm_ff      <= pwm_in;
         valid_ff    <= valid_in;
      end
      meas_ff <= meas_in;
      data_ff <= data_in;
      prod_ff <= mul_a * mul_b;
      acc_ff  <= acc_in;
      if (cmd.save_ki) begin
         ki_ff <= gain_sat;
      end
      if (cmd.save_kd) begin
         kd_ff <= gain_sat;
      end
   end

   assign status.pid_due  = due_ff;
   assign status.div_done = div_done;
   assign status.out_free = !valid_ff || rsp_tready;
   assign rsp_tvalid      = valid_ff;
   assign rsp_tdata       = data_ff;

endmodule

`default_nettype wire

// File: rtl/core/pid_heater_pwm_controller_core.sv
// A tick without a PID step goes from acceptance through the check to the commit.
// A tick with a PID step derives both gains in turn with the shared bit-serial divider,
// one quotient bit per cycle, then forms and sums the P, I and D terms before the commit.
// One tick is in work at a time; the commit waits until the result register is free.
// Synchronous active-high reset loads CSR defaults, clears FSM, error and output state.
`default_nettype none

module pid_heater_pwm_controller_core import phpc_pkg::*; #(
   parameter int SAMPLE_BITS = 12,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,  // [11:0] measured
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [31:0]                rsp_tdata,  // [0] heater_on, [16:1] duty,
                                                  // [17] computed, [30:18] error
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   phpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   phpc_dpath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire
